@@ rtl/met_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// met_pkg: shared types and constants of the escape-time pixel engine
// Fixed-point formats, register indexes, sequencer states and the control
// bundle passed from the sequencer to the datapath.
// ----------------------------------------------------------------------------
package met_pkg;

  // Fixed-point formats: c is Q4.FRAC_BITS, iterates are Q8.FRAC_BITS
  localparam int FRAC_BITS = 28;
  localparam int ZW        = FRAC_BITS + 8;     // iterate width
  localparam int HW        = (ZW + 1) / 2;      // multiplier chunk width
  localparam int PW        = ZW + 2 * HW;       // full product width
  localparam int CFG_W     = 32;
  localparam int IDX_W     = 3;
  localparam int STEP_W    = 31;
  localparam int SIZE_W    = 13;
  localparam int PIX_W     = 12;
  localparam int DW        = PIX_W + 2;         // signed 2p - size
  localparam int MAG_W     = DW - 1;            // |2p - size|
  localparam int LIM_W     = 16;

  // Hue wheel in half-degrees
  localparam int HUE_W      = 10;
  localparam int HUE_STEP   = 7;
  localparam int HUE_MOD    = 720;
  localparam int HUE_SECTOR = 120;
  localparam int RAMP_NUM   = 17;
  localparam int RAMP_BASE  = 150;
  localparam int RECIP_10   = 6554;   // ceil(2^16 / 10), exact for x < 16384
  localparam int RECIP_SH   = 16;
  localparam int COLOR_LOW  = 50;
  localparam int COLOR_FULL = 255;

  // Register reset values
  localparam logic [CFG_W-1:0]  RST_CENTER_REAL = 32'hF800_0000;
  localparam logic [CFG_W-1:0]  RST_CENTER_IMAG = 32'h0000_0000;
  localparam logic [STEP_W-1:0] RST_STEP        = 31'd1048576;
  localparam logic [SIZE_W-1:0] RST_SIZE        = 13'd256;
  localparam logic [LIM_W-1:0]  RST_LIMIT       = 16'd256;

  typedef enum logic [IDX_W-1:0] {
    REG_CENTER_REAL = 3'd0,
    REG_CENTER_IMAG = 3'd1,
    REG_STEP_X      = 3'd2,
    REG_STEP_Y      = 3'd3,
    REG_WIDTH       = 3'd4,
    REG_HEIGHT      = 3'd5,
    REG_ITER_LIMIT  = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_X,
    ST_MAP_Y,
    ST_MAP_FIN,
    ST_CHECK,
    ST_RI_LO,
    ST_RI_HI,
    ST_RI_FIN,
    ST_RR_LO,
    ST_RR_HI,
    ST_II_LO,
    ST_II_HI,
    ST_II_FIN,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    OPS_MAP_X,
    OPS_MAP_Y,
    OPS_RI,
    OPS_RR,
    OPS_II
  } opsel_t;

  typedef struct packed {
    logic   pix_valid;
    logic   go_on;
    logic   out_free;
  } status_t;

  typedef struct packed {
    logic   busy;
    logic   accept;
    logic   mul_load;
    logic   mul_accum;
    opsel_t opsel;
    logic   cap_cre;
    logic   cap_cim;
    logic   cap_prod;
    logic   upd_re;
    logic   upd_im;
    logic   cap_re2;
    logic   cap_im2;
    logic   count;
    logic   out_load;
  } ctrl_t;

endpackage
`default_nettype wire

@@ rtl/mandelbrot_escape_time_pixel.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel: escape-time Mandelbrot pixel with hue coloring
// Maps a pixel to c, iterates z = z*z + c and colors the escape count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: pixel_valid / pixel_stall carry one beat of pixel_col and
//   pixel_row. pixel_stall stays high from the accepting edge until the
//   result beat is loaded into the output register.
//   Output channel: color_valid / color_stall carry red, green, blue,
//   escape_count and inside_set, held in an output register.
//   Config: cfg_write with cfg_index / cfg_data writes one register per edge;
//   write only while no pixel is in flight.
// Timing: after the accepting edge, states MAP_X, MAP_Y and MAP_FIN map the
//   pixel onto c; each iteration then runs the escape test in CHECK and
//   three products, each two passes through the single 36x18 multiplier,
//   plus rounding and update. The result is loaded in FINISH, and a new
//   pixel is accepted only in IDLE, once the last result has been loaded.
// Reset: rst (synchronous) returns the registers to their defaults, idles the
//   sequencer and empties the output register.
// Stall: a finished beat waits in the output register while color_stall is
//   high; the next pixel is computed meanwhile and waits in its last step.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel #(
  parameter int MAX_DIM    = 4096,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // configuration
  input  wire logic                         cfg_write,
  input  wire logic [met_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [met_pkg::CFG_W-1:0]    cfg_data,
  // pixel in
  input  wire logic                         pixel_valid,
  output      logic                         pixel_stall,
  input  wire logic [met_pkg::PIX_W-1:0]    pixel_col,
  input  wire logic [met_pkg::PIX_W-1:0]    pixel_row,
  // color out
  output      logic                         color_valid,
  input  wire logic                         color_stall,
  output      logic [7:0]                   red,
  output      logic [7:0]                   green,
  output      logic [7:0]                   blue,
  output      logic [15:0]                  escape_count,
  output      logic                         inside_set
);

  localparam int ZW     = met_pkg::ZW;
  localparam int HW     = met_pkg::HW;
  localparam int PW     = met_pkg::PW;
  localparam int CW_    = met_pkg::CFG_W;
  localparam int SW     = met_pkg::SIZE_W;
  localparam int DW     = met_pkg::DW;
  localparam int MW     = met_pkg::MAG_W;
  localparam int MPW    = met_pkg::STEP_W + MW;   // mapping product width
  localparam int SUMW   = MPW + 2;                // mapping sum width
  localparam int HUEW   = met_pkg::HUE_W;
  localparam logic [32:0] CMAX = (33'd1 << COUNT_BITS) - 33'd1;
  localparam logic [ZW:0] FOUR = (ZW+1)'(4) << met_pkg::FRAC_BITS;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CW_-1:0]                  center_real;
  logic [CW_-1:0]                  center_imag;
  logic [met_pkg::STEP_W-1:0]      pixel_step_x;
  logic [met_pkg::STEP_W-1:0]      pixel_step_y;
  logic [SW-1:0]                   image_width;
  logic [SW-1:0]                   image_height;
  logic [met_pkg::LIM_W-1:0]       iteration_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_real     <= met_pkg::RST_CENTER_REAL;
      center_imag     <= met_pkg::RST_CENTER_IMAG;
      pixel_step_x    <= met_pkg::RST_STEP;
      pixel_step_y    <= met_pkg::RST_STEP;
      image_width     <= met_pkg::RST_SIZE;
      image_height    <= met_pkg::RST_SIZE;
      iteration_limit <= met_pkg::RST_LIMIT;
    end else if (cfg_write) begin
      unique case (met_pkg::reg_idx_t'(cfg_index))
        met_pkg::REG_CENTER_REAL: center_real     <= cfg_data;
        met_pkg::REG_CENTER_IMAG: center_imag     <= cfg_data;
        met_pkg::REG_STEP_X:      pixel_step_x    <= cfg_data[met_pkg::STEP_W-1:0];
        met_pkg::REG_STEP_Y:      pixel_step_y    <= cfg_data[met_pkg::STEP_W-1:0];
        met_pkg::REG_WIDTH:       image_width     <= cfg_data[SW-1:0];
        met_pkg::REG_HEIGHT:      image_height    <= cfg_data[SW-1:0];
        met_pkg::REG_ITER_LIMIT:  iteration_limit <= cfg_data[met_pkg::LIM_W-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Clamp image size and limit to what the datapath supports
  logic [SW-1:0]         width_eff;
  logic [SW-1:0]         height_eff;
  logic [COUNT_BITS-1:0] limit;

  always_comb begin
    width_eff  = (32'(image_width)  > MAX_DIM) ? SW'(MAX_DIM) : image_width;
    height_eff = (32'(image_height) > MAX_DIM) ? SW'(MAX_DIM) : image_height;
    limit      = (33'(iteration_limit) > CMAX) ? COUNT_BITS'(CMAX)
                                               : COUNT_BITS'(iteration_limit);
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  met_pkg::status_t stat;
  met_pkg::ctrl_t   ctrl;

  met_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  assign pixel_stall = ctrl.busy;

  // --------------------------------------------------------------------------
  // Pixel offsets: 2p - size, kept as sign and magnitude
  // --------------------------------------------------------------------------
  logic [DW-1:0] dx_full;
  logic [DW-1:0] dy_full;
  logic [MW-1:0] dx_mag;
  logic [MW-1:0] dy_mag;
  logic          dx_neg;
  logic          dy_neg;

  assign dx_full = {1'b0, pixel_col, 1'b0} - {1'b0, width_eff};
  assign dy_full = {1'b0, pixel_row, 1'b0} - {1'b0, height_eff};

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      dx_neg <= dx_full[DW-1];
      dy_neg <= dy_full[DW-1];
      dx_mag <= dx_full[DW-1] ? MW'(~dx_full + DW'(1)) : dx_full[MW-1:0];
      dy_mag <= dy_full[DW-1] ? MW'(~dy_full + DW'(1)) : dy_full[MW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Iterate state
  // --------------------------------------------------------------------------
  logic [CW_-1:0]        c_re;
  logic [CW_-1:0]        c_im;
  logic [ZW-1:0]         re;
  logic [ZW-1:0]         im;
  logic [ZW-1:0]         re2;
  logic [ZW-1:0]         im2;
  logic [ZW-1:0]         ri;     // floor(2*re*im), saturated
  logic [COUNT_BITS-1:0] n;
  logic [HUEW-1:0]       hue;
  logic [HUEW-1:0]       hue_sum;
  logic [HUEW-1:0]       hue_next;

  // Shared multiplier
  logic [PW-1:0]   acc;
  logic [ZW-1:0]   fin;
  logic [ZW-1:0]   mul_a;
  logic [2*HW-1:0] mul_b;
  logic            mul_neg;
  logic            mul_half;

  function automatic logic [ZW-1:0] mag(input logic [ZW-1:0] v);
    mag = v[ZW-1] ? (~v + ZW'(1)) : v;
  endfunction

  // Saturate a two's complement value two bits wider than the iterate
  function automatic logic [ZW-1:0] sat_z(input logic [ZW+1:0] v);
    if (v[ZW+1:ZW-1] == 3'b000 || v[ZW+1:ZW-1] == 3'b111) begin
      sat_z = v[ZW-1:0];
    end else begin
      sat_z = v[ZW+1] ? {1'b1, {(ZW-1){1'b0}}} : {1'b0, {(ZW-1){1'b1}}};
    end
  endfunction

  // center + floor(+-P / 2), saturated to Q4
  function automatic logic [CW_-1:0] map_c(input logic [CW_-1:0] center,
                                           input logic [MPW-1:0] p,
                                           input logic           neg);
    logic [SUMW-1:0] half;
    logic [SUMW-1:0] sum;
    half = SUMW'(p[MPW-1:1]);
    if (neg) begin
      sum = {{(SUMW-CW_){center[CW_-1]}}, center} + ~half + SUMW'(!p[0]);
    end else begin
      sum = {{(SUMW-CW_){center[CW_-1]}}, center} + half;
    end
    if (sum[SUMW-1:CW_-1] == '0 || sum[SUMW-1:CW_-1] == '1) begin
      map_c = sum[CW_-1:0];
    end else begin
      map_c = sum[SUMW-1] ? {1'b1, {(CW_-1){1'b0}}} : {1'b0, {(CW_-1){1'b1}}};
    end
  endfunction

  // Route operands to the multiplier; low chunk on load, high chunk on accum
  always_comb begin
    unique case (ctrl.opsel)
      met_pkg::OPS_MAP_X: begin
        mul_a    = ZW'(pixel_step_x);
        mul_b    = (2*HW)'(dx_mag);
        mul_neg  = 1'b0;
        mul_half = 1'b0;
      end
      met_pkg::OPS_MAP_Y: begin
        mul_a    = ZW'(pixel_step_y);
        mul_b    = (2*HW)'(dy_mag);
        mul_neg  = 1'b0;
        mul_half = 1'b0;
      end
      met_pkg::OPS_RI: begin
        mul_a    = mag(re);
        mul_b    = (2*HW)'(mag(im));
        mul_neg  = re[ZW-1] ^ im[ZW-1];
        mul_half = 1'b1;
      end
      met_pkg::OPS_RR: begin
        mul_a    = mag(re);
        mul_b    = (2*HW)'(mag(re));
        mul_neg  = 1'b0;
        mul_half = 1'b0;
      end
      default: begin
        mul_a    = mag(im);
        mul_b    = (2*HW)'(mag(im));
        mul_neg  = 1'b0;
        mul_half = 1'b0;
      end
    endcase
  end

  met_mul u_mul (
    .clk     (clk),
    .load    (ctrl.mul_load),
    .accum   (ctrl.mul_accum),
    .neg_in  (mul_neg),
    .half_in (mul_half),
    .a       (mul_a),
    .b       (ctrl.mul_accum ? mul_b[2*HW-1:HW] : mul_b[HW-1:0]),
    .acc     (acc),
    .fin     (fin)
  );

  assign hue_sum  = hue + HUEW'(met_pkg::HUE_STEP);
  assign hue_next = (hue_sum >= HUEW'(met_pkg::HUE_MOD))
                  ? hue_sum - HUEW'(met_pkg::HUE_MOD) : hue_sum;

  // Each step: ri and re (old squares) together, then im, then the new squares
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      re  <= '0;
      im  <= '0;
      re2 <= '0;
      im2 <= '0;
      n   <= '0;
      hue <= '0;
    end else begin
      if (ctrl.cap_cre) c_re <= map_c(center_real, acc[MPW-1:0], dx_neg);
      if (ctrl.cap_cim) c_im <= map_c(center_imag, acc[MPW-1:0], dy_neg);
      if (ctrl.cap_prod) ri <= fin;
      if (ctrl.upd_re) begin
        re <= sat_z({2'b00, re2} - {2'b00, im2}
                    + {{(ZW+2-CW_){c_re[CW_-1]}}, c_re});
      end
      if (ctrl.upd_im) begin
        im <= sat_z({{2{ri[ZW-1]}}, ri} + {{(ZW+2-CW_){c_im[CW_-1]}}, c_im});
      end
      if (ctrl.cap_re2) re2 <= fin;
      if (ctrl.cap_im2) im2 <= fin;
      if (ctrl.count) begin
        n   <= n + COUNT_BITS'(1);
        hue <= hue_next;
      end
    end
  end

  // Escape test: squares are never negative
  assign stat.pix_valid = pixel_valid;
  assign stat.go_on     = (({1'b0, re2} + {1'b0, im2}) <= FOUR) && (n < limit);
  assign stat.out_free  = !color_valid || !color_stall;

  // --------------------------------------------------------------------------
  // Coloring and output register
  // --------------------------------------------------------------------------
  logic       in_set;
  logic [7:0] red_c;
  logic [7:0] green_c;
  logic [7:0] blue_c;

  assign in_set = (n == limit);

  met_color u_color (
    .hue    (hue),
    .in_set (in_set),
    .red    (red_c),
    .green  (green_c),
    .blue   (blue_c)
  );

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      red          <= red_c;
      green        <= green_c;
      blue         <= blue_c;
      escape_count <= 16'(n);
      inside_set   <= in_set;
    end
  end

  // Hold the beat until taken; a new load only lands in a free slot
  always_ff @(posedge clk) begin
    if (rst) begin
      color_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      color_valid <= 1'b1;
    end else if (!color_stall) begin
      color_valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_stall |=> pixel_stall)
    else $error("sequencer did not start after a pixel beat");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |-> (!color_valid || !color_stall))
    else $error("result loaded over a stalled beat");

  a_inside_black: assert property (@(posedge clk) disable iff (rst)
    color_valid && inside_set |-> (red == 8'd0 && green == 8'd0 && blue == 8'd0))
    else $error("inside pixel is not black");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    ctrl.count |=> (hue < HUEW'(met_pkg::HUE_MOD)))
    else $error("hue left the wheel");

  a_squares_pos: assert property (@(posedge clk) disable iff (rst)
    ctrl.cap_im2 |=> (!re2[ZW-1] && !im2[ZW-1]))
    else $error("negative square");

endmodule
`default_nettype wire

@@ rtl/met_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// met_mul: shared multiply-accumulate unit with fixed-point rounding
// Builds a ZW x 2*HW magnitude product in two chunk passes, then floors,
// signs and saturates it into the Q8 iterate format.
// ----------------------------------------------------------------------------
module met_mul (
  input  wire logic                    clk,
  input  wire logic                    load,
  input  wire logic                    accum,
  input  wire logic                    neg_in,
  input  wire logic                    half_in,
  input  wire logic [met_pkg::ZW-1:0]  a,
  input  wire logic [met_pkg::HW-1:0]  b,
  output      logic [met_pkg::PW-1:0]  acc,
  output      logic [met_pkg::ZW-1:0]  fin
);

  localparam int ZW = met_pkg::ZW;
  localparam int HW = met_pkg::HW;
  localparam int PW = met_pkg::PW;
  localparam int FB = met_pkg::FRAC_BITS;
  localparam int QW = PW - FB + 1;
  localparam logic [ZW-1:0] QMAX = {1'b0, {(ZW-1){1'b1}}};
  localparam logic [ZW-1:0] QMIN = {1'b1, {(ZW-1){1'b0}}};

  logic [ZW+HW-1:0] prod;
  logic             neg;
  logic             half;
  logic [QW-1:0]    q;
  logic             rem;
  logic             ovf;

  assign prod = (ZW+HW)'(a) * (ZW+HW)'(b);

  // Low chunk loads the accumulator, high chunk adds in shifted
  always_ff @(posedge clk) begin
    if (load) begin
      acc  <= PW'(prod);
      neg  <= neg_in;
      half <= half_in;
    end else if (accum) begin
      acc <= acc + (PW'(prod) << HW);
    end
  end

  // Drop low bits toward minus infinity, then saturate
  always_comb begin
    if (half) begin
      q   = QW'(acc >> (FB - 1));
      rem = |acc[FB-2:0];
    end else begin
      q   = QW'(acc >> FB);
      rem = |acc[FB-1:0];
    end
    ovf = q > QW'(QMAX);
    priority if (ovf) begin
      fin = neg ? QMIN : QMAX;
    end else if (neg) begin
      fin = rem ? ~q[ZW-1:0] : (~q[ZW-1:0] + ZW'(1));
    end else begin
      fin = q[ZW-1:0];
    end
  end

endmodule
`default_nettype wire

@@ rtl/met_color.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// met_color: hue wheel coloring
// Maps a hue in half-degrees to RGB; pixels inside the set come out black.
// ----------------------------------------------------------------------------
module met_color (
  input  wire logic [met_pkg::HUE_W-1:0] hue,
  input  wire logic                      in_set,
  output      logic [7:0]                red,
  output      logic [7:0]                green,
  output      logic [7:0]                blue
);

  localparam int HW_ = met_pkg::HUE_W;
  localparam int SEC = met_pkg::HUE_SECTOR;
  localparam logic [7:0]  LOW  = 8'(met_pkg::COLOR_LOW);
  localparam logic [7:0]  FULL = 8'(met_pkg::COLOR_FULL);
  localparam logic [7:0]  MID  = 8'(SEC);

  typedef enum logic [2:0] {
    SEC_RED_UP,
    SEC_GREEN_DOWN,
    SEC_GREEN_UP,
    SEC_BLUE_DOWN,
    SEC_BLUE_UP,
    SEC_RED_DOWN
  } sector_t;

  sector_t        sector;
  logic [HW_-1:0] t_full;
  logic [7:0]     t;
  logic [6:0]     d;
  logic [7:0]     span;
  logic [11:0]    x;
  logic [24:0]    scaled;
  logic [7:0]     ramp;

  always_comb begin
    priority if (hue >= HW_'(5 * SEC)) sector = SEC_RED_DOWN;
    else if (hue >= HW_'(4 * SEC))     sector = SEC_BLUE_UP;
    else if (hue >= HW_'(3 * SEC))     sector = SEC_BLUE_DOWN;
    else if (hue >= HW_'(2 * SEC))     sector = SEC_GREEN_UP;
    else if (hue >= HW_'(SEC))         sector = SEC_GREEN_DOWN;
    else                               sector = SEC_RED_UP;

    // Fold to hue mod 240, distance from the midpoint of that span
    priority if (hue >= HW_'(4 * SEC)) t_full = hue - HW_'(4 * SEC);
    else if (hue >= HW_'(2 * SEC))     t_full = hue - HW_'(2 * SEC);
    else                               t_full = hue;
    t = t_full[7:0];
    d = (t >= MID) ? 7'(t - MID) : 7'(MID - t);

    // floor(17 * (150 - d) / 10) by reciprocal multiply, LOW where d is 120
    span   = 8'(met_pkg::RAMP_BASE) - {1'b0, d};
    x      = 12'(met_pkg::RAMP_NUM) * {4'b0, span};
    scaled = {13'b0, x} * 25'(met_pkg::RECIP_10);
    ramp   = (d == 7'(SEC)) ? LOW : scaled[met_pkg::RECIP_SH+7:met_pkg::RECIP_SH];
  end

  always_comb begin
    red   = '0;
    green = '0;
    blue  = '0;
    if (!in_set) begin
      unique case (sector)
        SEC_RED_UP:     begin red = FULL; green = ramp; blue = LOW;  end
        SEC_GREEN_DOWN: begin red = ramp; green = FULL; blue = LOW;  end
        SEC_GREEN_UP:   begin red = LOW;  green = FULL; blue = ramp; end
        SEC_BLUE_DOWN:  begin red = LOW;  green = ramp; blue = FULL; end
        SEC_BLUE_UP:    begin red = ramp; green = LOW;  blue = FULL; end
        default:        begin red = FULL; green = LOW;  blue = ramp; end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/met_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// met_seq: pixel sequencer
// Steps through mapping, the iteration schedule on the shared
// multiplier, and result hand-off.
// ----------------------------------------------------------------------------
module met_seq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire met_pkg::status_t stat,
  output      met_pkg::ctrl_t   ctrl
);

  met_pkg::state_t state;
  met_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= met_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      met_pkg::ST_IDLE:    if (stat.pix_valid) state_next = met_pkg::ST_MAP_X;
      met_pkg::ST_MAP_X:   state_next = met_pkg::ST_MAP_Y;
      met_pkg::ST_MAP_Y:   state_next = met_pkg::ST_MAP_FIN;
      met_pkg::ST_MAP_FIN: state_next = met_pkg::ST_CHECK;
      met_pkg::ST_CHECK: begin
        state_next = stat.go_on ? met_pkg::ST_RI_LO : met_pkg::ST_FINISH;
      end
      met_pkg::ST_RI_LO:   state_next = met_pkg::ST_RI_HI;
      met_pkg::ST_RI_HI:   state_next = met_pkg::ST_RI_FIN;
      met_pkg::ST_RI_FIN:  state_next = met_pkg::ST_RR_LO;
      met_pkg::ST_RR_LO:   state_next = met_pkg::ST_RR_HI;
      met_pkg::ST_RR_HI:   state_next = met_pkg::ST_II_LO;
      met_pkg::ST_II_LO:   state_next = met_pkg::ST_II_HI;
      met_pkg::ST_II_HI:   state_next = met_pkg::ST_II_FIN;
      met_pkg::ST_II_FIN:  state_next = met_pkg::ST_CHECK;
      met_pkg::ST_FINISH:  if (stat.out_free) state_next = met_pkg::ST_IDLE;
      default:             state_next = met_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl      = '0;
    ctrl.busy = (state != met_pkg::ST_IDLE);
    unique case (state)
      met_pkg::ST_IDLE:    ctrl.accept = stat.pix_valid;
      met_pkg::ST_MAP_X: begin
        ctrl.mul_load = 1'b1;
        ctrl.opsel    = met_pkg::OPS_MAP_X;
      end
      met_pkg::ST_MAP_Y: begin
        ctrl.mul_load = 1'b1;
        ctrl.opsel    = met_pkg::OPS_MAP_Y;
        ctrl.cap_cre  = 1'b1;
      end
      met_pkg::ST_MAP_FIN: ctrl.cap_cim = 1'b1;
      met_pkg::ST_CHECK:   ctrl.busy = 1'b1;
      met_pkg::ST_RI_LO: begin
        ctrl.mul_load = 1'b1;
        ctrl.opsel    = met_pkg::OPS_RI;
      end
      met_pkg::ST_RI_HI: begin
        ctrl.mul_accum = 1'b1;
        ctrl.opsel     = met_pkg::OPS_RI;
      end
      met_pkg::ST_RI_FIN: begin
        ctrl.cap_prod = 1'b1;
        ctrl.upd_re   = 1'b1;
      end
      met_pkg::ST_RR_LO: begin
        ctrl.mul_load = 1'b1;
        ctrl.opsel    = met_pkg::OPS_RR;
        ctrl.upd_im   = 1'b1;
      end
      met_pkg::ST_RR_HI: begin
        ctrl.mul_accum = 1'b1;
        ctrl.opsel     = met_pkg::OPS_RR;
      end
      met_pkg::ST_II_LO: begin
        ctrl.mul_load = 1'b1;
        ctrl.opsel    = met_pkg::OPS_II;
        ctrl.cap_re2  = 1'b1;
      end
      met_pkg::ST_II_HI: begin
        ctrl.mul_accum = 1'b1;
        ctrl.opsel     = met_pkg::OPS_II;
      end
      met_pkg::ST_II_FIN: begin
        ctrl.cap_im2 = 1'b1;
        ctrl.count   = 1'b1;
      end
      met_pkg::ST_FINISH:  ctrl.out_load = stat.out_free;
      default:             ctrl.busy = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: escape-time Mandelbrot pixel engine testbench
// Drives pixel beats through the valid/stall channel, reprograms the view and
// iteration limit between phases, and compares every color beat against an
// in-bench fixed-point model of the escape loop and the hue wheel.
// ----------------------------------------------------------------------------
module tb;

  localparam int     FB        = met_pkg::FRAC_BITS;
  localparam int     CFG_W     = met_pkg::CFG_W;
  localparam int     PIX_W     = met_pkg::PIX_W;
  localparam int     STEP_W    = met_pkg::STEP_W;
  localparam int     SIZE_W    = met_pkg::SIZE_W;
  localparam int     LIM_W     = met_pkg::LIM_W;
  localparam int     SECTOR    = met_pkg::HUE_SECTOR;
  localparam int     C_LOW     = met_pkg::COLOR_LOW;
  localparam int     C_FULL    = met_pkg::COLOR_FULL;
  localparam int     DIM_MAX   = 4096;
  localparam int     RAMP_DEN  = 10;                 // ramp slope is 17/10
  localparam longint Z_MAX     = (longint'(1) << (FB + 7)) - 1;
  localparam longint Z_MIN     = -Z_MAX - 1;
  localparam longint C_MAX     = (longint'(1) << (FB + 3)) - 1;
  localparam longint C_MIN     = -C_MAX - 1;
  localparam longint ESC_BOUND = longint'(4) << FB;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] escape_count;
    logic        inside_set;
  } color_t;

  // Hue wheel sectors, each 60 degrees (120 half-degrees) wide
  typedef enum int {
    SECT_RED, SECT_YELLOW, SECT_GREEN, SECT_CYAN, SECT_BLUE, SECT_MAGENTA
  } hue_sector_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps a copy of the view registers, predicts the color of each
  // accepted pixel and checks color beats in order.
  // --------------------------------------------------------------------------
  class pixel_scoreboard;
    color_t colors_due[$];
    int     errors;
    longint center_re, center_im, step_x, step_y, width, height, limit;

    function new();
      errors    = 0;
      center_re = longint'($signed(met_pkg::RST_CENTER_REAL));
      center_im = longint'($signed(met_pkg::RST_CENTER_IMAG));
      step_x    = longint'(met_pkg::RST_STEP);
      step_y    = longint'(met_pkg::RST_STEP);
      width     = longint'(met_pkg::RST_SIZE);
      height    = longint'(met_pkg::RST_SIZE);
      limit     = longint'(met_pkg::RST_LIMIT);
    endfunction

    function void set_reg(met_pkg::reg_idx_t idx, logic [CFG_W-1:0] data);
      case (idx)
        met_pkg::REG_CENTER_REAL: center_re = longint'($signed(data));
        met_pkg::REG_CENTER_IMAG: center_im = longint'($signed(data));
        met_pkg::REG_STEP_X:      step_x    = longint'(data[STEP_W-1:0]);
        met_pkg::REG_STEP_Y:      step_y    = longint'(data[STEP_W-1:0]);
        met_pkg::REG_WIDTH:       width     = longint'(data[SIZE_W-1:0]);
        met_pkg::REG_HEIGHT:      height    = longint'(data[SIZE_W-1:0]);
        met_pkg::REG_ITER_LIMIT:  limit     = longint'(data[LIM_W-1:0]);
        default: ;
      endcase
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // Exact product, floor of the shift, then saturate to Q8
    function longint fixed_mul(longint a, longint b, int sh);
      logic signed [127:0] wa, wb, prod;
      wa   = a;
      wb   = b;
      prod = (wa * wb) >>> sh;
      if (prod > Z_MAX) return Z_MAX;
      if (prod < Z_MIN) return Z_MIN;
      return longint'(prod);
    endfunction

    // center + floor(step * (2p - size) / 2), saturated to Q4
    function longint axis_point(longint ctr, longint step, longint p, longint size);
      longint prod;
      prod = step * (2 * p - size);
      return clamp(ctr + (prod >>> 1), C_MIN, C_MAX);
    endfunction

    function color_t escape_color(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
      color_t     res;
      longint     c_re, c_im, re, im, re2, im2, w, h;
      int         n, hue, t, d, ramp;
      logic [7:0] lo8, full8, ramp8;
      w    = (width > DIM_MAX) ? DIM_MAX : width;
      h    = (height > DIM_MAX) ? DIM_MAX : height;
      c_re = axis_point(center_re, step_x, longint'(col), w);
      c_im = axis_point(center_im, step_y, longint'(row), h);
      re   = 0;
      im   = 0;
      re2  = 0;
      im2  = 0;
      n    = 0;
      // z = z*z + c; the cross term is 2*re*im, i.e. one bit less shift
      while (re2 + im2 <= ESC_BOUND && n < limit) begin
        im  = clamp(fixed_mul(re, im, FB - 1) + c_im, Z_MIN, Z_MAX);
        re  = clamp(re2 - im2 + c_re, Z_MIN, Z_MAX);
        re2 = fixed_mul(re, re, FB);
        im2 = fixed_mul(im, im, FB);
        n++;
      end
      res.escape_count = 16'(n);
      res.inside_set   = (n == limit);
      res.red          = '0;
      res.green        = '0;
      res.blue         = '0;
      if (!res.inside_set) begin
        hue   = (met_pkg::HUE_STEP * n) % met_pkg::HUE_MOD;
        t     = hue % (2 * SECTOR);
        d     = (t >= SECTOR) ? t - SECTOR : SECTOR - t;
        ramp  = (d == SECTOR) ? C_LOW
              : met_pkg::RAMP_NUM * (met_pkg::RAMP_BASE - d) / RAMP_DEN;
        lo8   = 8'(C_LOW);
        full8 = 8'(C_FULL);
        ramp8 = 8'(ramp);
        case (hue_sector_t'(hue / SECTOR))
          SECT_RED:    begin res.red = full8; res.green = ramp8; res.blue = lo8;   end
          SECT_YELLOW: begin res.red = ramp8; res.green = full8; res.blue = lo8;   end
          SECT_GREEN:  begin res.red = lo8;   res.green = full8; res.blue = ramp8; end
          SECT_CYAN:   begin res.red = lo8;   res.green = ramp8; res.blue = full8; end
          SECT_BLUE:   begin res.red = ramp8; res.green = lo8;   res.blue = full8; end
          default:     begin res.red = full8; res.green = lo8;   res.blue = ramp8; end
        endcase
      end
      return res;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
      colors_due.push_back(escape_color(col, row));
    endfunction

    function int pending();
      return colors_due.size();
    endfunction

    task report_mismatch(string what, longint got, longint want);
      errors++;
      $display("mismatch: %s got %0d expected %0d", what, got, want);
    endtask

    task check_color(color_t got);
      color_t want;
      if (colors_due.size() == 0) begin
        report_mismatch("color beat with no pixel pending, count", got.escape_count, 0);
        return;
      end
      want = colors_due.pop_front();
      if (got.red !== want.red)     report_mismatch("red", got.red, want.red);
      if (got.green !== want.green) report_mismatch("green", got.green, want.green);
      if (got.blue !== want.blue)   report_mismatch("blue", got.blue, want.blue);
      if (got.escape_count !== want.escape_count)
        report_mismatch("escape_count", got.escape_count, want.escape_count);
      if (got.inside_set !== want.inside_set)
        report_mismatch("inside_set", got.inside_set, want.inside_set);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Block under test; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                      clk;
  logic                      rst         = 1'b1;
  logic                      cfg_write   = 1'b0;
  logic [met_pkg::IDX_W-1:0] cfg_index   = '0;
  logic [CFG_W-1:0]          cfg_data    = '0;
  logic                      pixel_valid = 1'b0;
  logic                      pixel_stall;
  logic [PIX_W-1:0]          pixel_col   = '0;
  logic [PIX_W-1:0]          pixel_row   = '0;
  logic                      color_valid;
  logic                      color_stall = 1'b0;
  logic [7:0]                red, green, blue;
  logic [15:0]               escape_count;
  logic                      inside_set;

  mandelbrot_escape_time_pixel dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel_col    (pixel_col),
    .pixel_row    (pixel_row),
    .color_valid  (color_valid),
    .color_stall  (color_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .escape_count (escape_count),
    .inside_set   (inside_set)
  );

  pixel_scoreboard sb;
  color_t          seen;
  int              send_idle_pct  = 0;
  int              recv_stall_pct = 0;
  logic            recv_hold      = 1'b0;
  longint          cycle_count    = 0;
  longint          run_budget     = 200000;   // grows with every pixel sent
  longint          cur_limit      = longint'(met_pkg::RST_LIMIT);
  int              span_x         = int'(met_pkg::RST_SIZE);
  int              span_y         = int'(met_pkg::RST_SIZE);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Receiver: random stalls, or a solid hold-off while recv_hold is set
  always @(posedge clk) begin
    color_stall <= recv_hold || ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Sample both channels on the edge; values seen here are the pre-edge ones
  always @(posedge clk) begin
    if (!rst && pixel_valid && !pixel_stall) sb.note_pixel(pixel_col, pixel_row);
    if (!rst && color_valid && !color_stall) begin
      seen = '{red, green, blue, escape_count, inside_set};
      sb.check_color(seen);
    end
  end

  // Watchdog: the budget is several times the slowest legal run so far
  initial begin : watchdog
    while (cycle_count <= run_budget) @(posedge clk);
    $display("tb: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 81; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 81; end
      default:       begin send_idle_pct = 6;  recv_stall_pct = 6;  end
    endcase
  endtask

  // One register per edge; cfg_write stays high across a burst of writes
  task automatic write_reg(input met_pkg::reg_idx_t idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // Reprogram the whole view; call only with no pixel in flight
  task automatic program_view(input logic [CFG_W-1:0] cr, input logic [CFG_W-1:0] ci,
                              input logic [CFG_W-1:0] sx, input logic [CFG_W-1:0] sy,
                              input logic [CFG_W-1:0] w,  input logic [CFG_W-1:0] h,
                              input logic [CFG_W-1:0] lim);
    write_reg(met_pkg::REG_CENTER_REAL, cr);
    write_reg(met_pkg::REG_CENTER_IMAG, ci);
    write_reg(met_pkg::REG_STEP_X, sx);
    write_reg(met_pkg::REG_STEP_Y, sy);
    write_reg(met_pkg::REG_WIDTH, w);
    write_reg(met_pkg::REG_HEIGHT, h);
    write_reg(met_pkg::REG_ITER_LIMIT, lim);
    cfg_write <= 1'b0;
    cur_limit = longint'(lim[LIM_W-1:0]);
    span_x    = (w[SIZE_W-1:0] > DIM_MAX) ? DIM_MAX : int'(w[SIZE_W-1:0]);
    span_y    = (h[SIZE_W-1:0] > DIM_MAX) ? DIM_MAX : int'(h[SIZE_W-1:0]);
    @(posedge clk);
  endtask

  // Offer one beat after a random gap and hold it until accepted. Valid is
  // left high on return so back-to-back beats never toggle it within a step.
  task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_col   <= col;
    pixel_row   <= row;
    run_budget  += 4 * (9 * cur_limit + 6) + 400;
    do @(posedge clk); while (pixel_stall);
  endtask

  // Drop valid and wait for every predicted color; the extra edge lets the
  // monitor note the beat accepted at the edge we returned on
  task automatic drain();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic hold_off_receiver(input int cycles);
    run_budget += 4 * cycles;
    recv_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    recv_hold <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return '0;                                   // empty image
      1:       return CFG_W'($urandom_range(DIM_MAX, 8191)); // clamped size
      default: return CFG_W'($urandom_range(1, 96));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_step();
    case ($urandom_range(0, 9))
      0:       return '0;                                   // everything at center
      1:       return 32'h7FFF_FFFF;
      default: return CFG_W'($urandom_range(1 << 15, 1 << 23));
    endcase
  endfunction

  // Mostly inside the image, sometimes any 12-bit position
  function automatic logic [PIX_W-1:0] pick_coord(input int span);
    if (span == 0 || $urandom_range(0, 9) == 0) return PIX_W'($urandom_range(0, 4095));
    return PIX_W'($urandom_range(0, span - 1));
  endfunction

  // Random view around the set; now and then a center anywhere in Q4.28
  task automatic random_view(input int lim_lo, input int lim_hi);
    logic [CFG_W-1:0] cr, ci;
    cr = ($urandom_range(0, 7) == 0) ? $urandom()
         : CFG_W'(-536870912 + int'($urandom_range(0, 700000000)));
    ci = ($urandom_range(0, 7) == 0) ? $urandom()
         : CFG_W'(-322122547 + int'($urandom_range(0, 644245094)));
    program_view(cr, ci, pick_step(), pick_step(), pick_size(), pick_size(),
                 CFG_W'($urandom_range(lim_lo, lim_hi)));
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int ph, k;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset view: corners, the center (inside at the default limit of 256)
    set_idling(IDLE_NONE);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd128, 12'd128);
    send_pixel(12'd0, 12'd128);
    send_pixel(12'd255, 12'd64);
    drain();

    // Center at the corner 8 - 8i of Q4.28, oversized width clamped, zero
    // height, widest limit: c lies near it and escapes on the first step
    program_view(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd1, 32'd8191, 32'd0, 32'd65535);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
    drain();

    // Limit zero: no iteration, inside with count zero
    program_view(32'd0, 32'd0, 32'd0, 32'd0, 32'd256, 32'd256, 32'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    drain();

    // Largest steps from the corner -8 + 8i: c saturates both ways
    program_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'd1, 32'd4096, 32'd3);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd1, 12'd2048);
    drain();

    // Zero step: every pixel lands on -0.75 + 0.1i near the boundary
    program_view(32'hF400_0000, 32'd26843546, 32'd0, 32'd0, 32'd4096, 32'd64, 32'd40);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd17);
    send_pixel(12'd2048, 12'd4095);
    drain();

    // Random phases; two of them run long limits so the hue wheel wraps
    for (ph = 0; ph < 17; ph++) begin
      set_idling(idle_mode_t'(ph % 4));
      if (ph % 8 == 5) random_view(104, 130);
      else random_view(1, 40);
      for (k = 0; k < 100; k++) begin
        // Receiver goes quiet while the sender keeps offering: the output
        // register fills, the next pixel parks and the input stalls
        if (ph == 6 && k == 10) fork hold_off_receiver(3000); join_none
        // Sender pauses until every color has come back
        if (ph == 9 && k == 50) drain();
        send_pixel(pick_coord(span_x), pick_coord(span_y));
      end
      drain();
    end

    // Let any stray beat surface before the verdict
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule

@@ mandelbrot_escape_time_pixel.f @@
rtl/met_pkg.sv
rtl/met_mul.sv
rtl/met_color.sv
rtl/met_seq.sv
rtl/mandelbrot_escape_time_pixel.sv
sim/tb.sv
